### rtl/core/csbc_pkg.sv
package csbc_pkg;

	// Width of a count as it travels from the front to the back.
	localparam int unsigned CNT_W = 16;
	localparam int unsigned LEVEL_W = 16;

	// Color lanes, in capture order.
	localparam logic [1:0] LANE_RED   = 2'd0;
	localparam logic [1:0] LANE_GREEN = 2'd1;
	localparam logic [1:0] LANE_BLUE  = 2'd2;

	// One command from the sequencer to the scaling unit.
	typedef struct packed {
		logic             do_scale;
		logic [1:0]       lane;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] ref_count;
		logic [1:0]       filter_select;
		logic [1:0]       scale_pins;
		logic             balanced;
		logic             triple;
	} cmd_t;

endpackage

### rtl/core/csbc_cmd_fifo.sv
module csbc_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  csbc_pkg::cmd_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output csbc_pkg::cmd_t  rd_data,
	output logic            empty
);

	csbc_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/csbc_front.sv
module csbc_front #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [csbc_pkg::CNT_W-1:0]   pulse_count,
	input  logic                         recognize_enable,
	input  logic [1:0]                   output_scaling,
	output csbc_pkg::cmd_t               cmd
);

	localparam int unsigned REF_W =
		(COUNT_WIDTH < csbc_pkg::CNT_W) ? COUNT_WIDTH : csbc_pkg::CNT_W;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_RED   = 3'd1;
	localparam logic [2:0] PH_GREEN = 3'd2;
	localparam logic [2:0] PH_BLUE  = 3'd3;
	localparam logic [2:0] PH_CLEAR = 3'd4;

	logic [2:0]       phase_q;
	logic             bal_q;
	logic [REF_W-1:0] ref_q [3];
	logic [REF_W-1:0] count;
	logic [2:0]       phase_nx;
	logic             bal_nx;
	logic             cap_en;
	logic [1:0]       lane;

	assign count = pulse_count[REF_W-1:0];

	always_comb begin
		phase_nx      = phase_q;
		bal_nx        = bal_q;
		cap_en        = 1'b0;
		lane          = csbc_pkg::LANE_RED;
		cmd           = '0;
		if (!bal_q) begin
			case (phase_q)
				PH_START: phase_nx = PH_RED;
				PH_RED: begin
					cap_en   = 1'b1;
					lane     = csbc_pkg::LANE_RED;
					phase_nx = PH_GREEN;
				end
				PH_GREEN: begin
					cap_en   = 1'b1;
					lane     = csbc_pkg::LANE_GREEN;
					phase_nx = PH_BLUE;
				end
				PH_BLUE: begin
					cap_en   = 1'b1;
					lane     = csbc_pkg::LANE_BLUE;
					phase_nx = PH_CLEAR;
				end
				PH_CLEAR: begin
					bal_nx   = 1'b1;
					phase_nx = PH_START;
				end
				default: phase_nx = PH_START;
			endcase
		end else if (recognize_enable) begin
			case (phase_q)
				PH_START: phase_nx = PH_RED;
				PH_RED: begin
					cmd.do_scale = 1'b1;
					lane         = csbc_pkg::LANE_RED;
					phase_nx     = PH_GREEN;
				end
				PH_GREEN: begin
					cmd.do_scale = 1'b1;
					lane         = csbc_pkg::LANE_GREEN;
					phase_nx     = PH_BLUE;
				end
				PH_BLUE: begin
					cmd.do_scale = 1'b1;
					cmd.triple   = 1'b1;
					lane         = csbc_pkg::LANE_BLUE;
					phase_nx     = PH_START;
				end
				default: phase_nx = PH_START;
			endcase
		end
		cmd.lane          = lane;
		cmd.count         = csbc_pkg::CNT_W'(count);
		cmd.ref_count     = csbc_pkg::CNT_W'(ref_q[lane]);
		cmd.filter_select = (phase_nx == PH_RED || phase_nx == PH_GREEN ||
			phase_nx == PH_BLUE) ? phase_nx[1:0] : 2'd0;
		cmd.scale_pins    = output_scaling;
		cmd.balanced      = bal_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			bal_q   <= 1'b0;
			ref_q   <= '{default: '0};
		end else if (take) begin
			phase_q <= phase_nx;
			bal_q   <= bal_nx;
			if (cap_en) begin
				ref_q[lane] <= count;
			end
		end
	end

endmodule

### rtl/core/csbc_back.sv
module csbc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  csbc_pkg::cmd_t                 cmd,
	input  logic                           cmd_empty,
	output logic                           cmd_pop,
	input  logic                           pop,
	output logic                           empty,
	output logic [1:0]                     filter_select,
	output logic [1:0]                     scale_pins,
	output logic                           balanced,
	output logic [csbc_pkg::LEVEL_W-1:0]   red_level,
	output logic [csbc_pkg::LEVEL_W-1:0]   green_level,
	output logic [csbc_pkg::LEVEL_W-1:0]   blue_level,
	output logic [2:0]                     color_class,
	output logic                           triple_done
);

	localparam int unsigned CW    = csbc_pkg::CNT_W;
	localparam int unsigned LW    = csbc_pkg::LEVEL_W;
	localparam int unsigned NUM_W = CW + 8;
	localparam int unsigned STEP_W = $clog2(NUM_W + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [2:0] CLS_NONE  = 3'd0;
	localparam logic [2:0] CLS_WHITE = 3'd1;
	localparam logic [2:0] CLS_BLACK = 3'd2;
	localparam logic [2:0] CLS_RED   = 3'd3;
	localparam logic [2:0] CLS_GREEN = 3'd4;
	localparam logic [2:0] CLS_BLUE  = 3'd5;

	function automatic logic in_box(input logic [LW-1:0] v, input int unsigned lo,
		input int unsigned hi);
		return (v >= LW'(lo)) && (v <= LW'(hi));
	endfunction

	function automatic logic [2:0] classify(input logic [LW-1:0] r, input logic [LW-1:0] g,
		input logic [LW-1:0] b);
		logic [2:0] c;
		c = CLS_NONE;
		if (in_box(r, 235, 255) && in_box(g, 235, 255) && in_box(b, 235, 255)) begin
			c = CLS_WHITE;
		end else if (in_box(r, 10, 50) && in_box(g, 10, 50) && in_box(b, 10, 50)) begin
			c = CLS_BLACK;
		end else if (in_box(r, 155, 195) && in_box(g, 26, 66) && in_box(b, 37, 77)) begin
			c = CLS_RED;
		end else if (in_box(r, 25, 65) && in_box(g, 70, 110) && in_box(b, 53, 93)) begin
			c = CLS_GREEN;
		end else if (in_box(r, 26, 66) && in_box(g, 39, 79) && in_box(b, 73, 113)) begin
			c = CLS_BLUE;
		end
		return c;
	endfunction

	logic [1:0]        state_q;
	csbc_pkg::cmd_t    cur_q;
	logic [NUM_W-1:0]  quo_q;
	logic [CW-1:0]     rem_q;
	logic [STEP_W-1:0] step_q;
	logic [LW-1:0]     lvl_q [3];
	logic [2:0]        cls_q;
	logic              out_valid_q;
	logic [1:0]        o_filter_q;
	logic [1:0]        o_pins_q;
	logic              o_bal_q;
	logic [LW-1:0]     o_lvl_q [3];
	logic [2:0]        o_cls_q;
	logic              o_triple_q;

	logic [CW:0]       rem_try;
	logic [CW:0]       rem_sub;
	logic              q_bit;
	logic [LW-1:0]     sat_level;
	logic [2:0]        cls_new;

	assign rem_try   = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub   = rem_try - {1'b0, cur_q.ref_count};
	assign q_bit     = (rem_try >= {1'b0, cur_q.ref_count});
	assign sat_level = (quo_q[NUM_W-1:LW] != '0) ? '1 : quo_q[LW-1:0];
	assign cls_new   = classify(lvl_q[0], lvl_q[1], lvl_q[2]);

	assign cmd_pop       = (state_q == ST_IDLE) && !cmd_empty && !out_valid_q;
	assign empty         = !out_valid_q;
	assign filter_select = o_filter_q;
	assign scale_pins    = o_pins_q;
	assign balanced      = o_bal_q;
	assign red_level     = o_lvl_q[0];
	assign green_level   = o_lvl_q[1];
	assign blue_level    = o_lvl_q[2];
	assign color_class   = o_cls_q;
	assign triple_done   = o_triple_q;

	// Datapath registers: divider and the output item.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					cur_q  <= cmd;
					quo_q  <= {cmd.count, 8'd0} - {8'd0, cmd.count};
					rem_q  <= '0;
					step_q <= STEP_W'(NUM_W);
					if (!cmd.do_scale) begin
						o_filter_q <= cmd.filter_select;
						o_pins_q   <= cmd.scale_pins;
						o_bal_q    <= cmd.balanced;
						o_lvl_q    <= lvl_q;
						o_cls_q    <= cls_q;
						o_triple_q <= 1'b0;
					end
				end
			end
			ST_DIV: begin
				if (step_q != '0) begin
					rem_q  <= q_bit ? rem_sub[CW-1:0] : rem_try[CW-1:0];
					quo_q  <= {quo_q[NUM_W-2:0], q_bit};
					step_q <= step_q - STEP_W'(1);
				end
			end
			ST_FIN: begin
				o_filter_q <= cur_q.filter_select;
				o_pins_q   <= cur_q.scale_pins;
				o_bal_q    <= cur_q.balanced;
				o_lvl_q    <= lvl_q;
				o_triple_q <= cur_q.triple;
				o_cls_q    <= cur_q.triple ? cls_new : cls_q;
			end
			default: begin
			end
		endcase
	end

	// Scaled levels and class: store the level after the last step, update the
	// class after blue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '{default: '0};
			cls_q <= CLS_NONE;
		end else begin
			if (state_q == ST_DIV && step_q == '0) begin
				lvl_q[cur_q.lane] <= sat_level;
			end
			if (state_q == ST_FIN && cur_q.triple) begin
				cls_q <= cls_new;
			end
		end
	end

	// Control: sequencer state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.do_scale) begin
							state_q <= ST_DIV;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (pop) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/color_sensor_balance_and_classify.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          pulse_count
// result    out        empty / pop          filter_select, scale_pins, balanced,
//                                           red_level, green_level, blue_level,
//                                           color_class, triple_done
// config    in         cfg_we               cfg_index, cfg_data
//
// An item is taken by the sequencer; items that need no scaling are loaded into the
// result register at the edge that pops them from the command queue. A scaling item
// holds the back end for one load, 24 restoring-division steps (one quotient bit
// each), one step to store the level and one to classify and post the item.
// Reset clears the sequencer, references, levels, class, queue and result valid.
// The two-entry command queue lets push continue while a result waits for pop.
module color_sensor_balance_and_classify #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] pulse_count,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  filter_select,
	output logic [1:0]  scale_pins,
	output logic        balanced,
	output logic [15:0] red_level,
	output logic [15:0] green_level,
	output logic [15:0] blue_level,
	output logic [2:0]  color_class,
	output logic        triple_done,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);

	// Register indexes of the configuration port.
	localparam logic REG_RECOGNIZE = 1'b0;
	localparam logic REG_SCALING   = 1'b1;

	logic           recognize_q;
	logic [1:0]     scaling_q;
	csbc_pkg::cmd_t front_cmd;
	csbc_pkg::cmd_t back_cmd;
	logic           take;
	logic           cmd_empty;
	logic           cmd_pop;

	// Accept an item only when the queue has room for its command.
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recognize_q <= 1'b0;
			scaling_q   <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECOGNIZE: recognize_q <= cfg_data[0];
				REG_SCALING:   scaling_q   <= cfg_data;
				default:       recognize_q <= recognize_q;
			endcase
		end
	end

	// Front: filter sequencing, reference capture, command build.
	csbc_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.pulse_count      (pulse_count),
		.recognize_enable (recognize_q),
		.output_scaling   (scaling_q),
		.cmd              (front_cmd)
	);

	// Decouple the sequencer from the divider.
	csbc_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (back_cmd),
		.empty   (cmd_empty)
	);

	// Back: count*255/reference, saturate, classify after blue, post the item.
	csbc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (back_cmd),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.pop           (pop),
		.empty         (empty),
		.filter_select (filter_select),
		.scale_pins    (scale_pins),
		.balanced      (balanced),
		.red_level     (red_level),
		.green_level   (green_level),
		.blue_level    (blue_level),
		.color_class   (color_class),
		.triple_done   (triple_done)
	);

endmodule

### sim/color_sensor_balance_and_classify_tb.sv
module color_sensor_balance_and_classify_tb;

	// Filter for the next window, as driven on filter_select.
	typedef enum logic [1:0] {
		FILTER_CLEAR = 2'd0,
		FILTER_RED   = 2'd1,
		FILTER_GREEN = 2'd2,
		FILTER_BLUE  = 2'd3
	} filter_e;

	// Frequency scaling codes held in the scaling register.
	typedef enum logic [1:0] {
		SCALE_OFF   = 2'd0,
		SCALE_2PCT  = 2'd1,
		SCALE_20PCT = 2'd2,
		SCALE_FULL  = 2'd3
	} scale_e;

	// Color classes, in the order the boxes are tried.
	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_WHITE = 3'd1,
		CLS_BLACK = 3'd2,
		CLS_RED   = 3'd3,
		CLS_GREEN = 3'd4,
		CLS_BLUE  = 3'd5
	} color_e;

	// Sequencer phase: clear window, the three filter windows, and the settle
	// window that ends white balance.
	typedef enum logic [2:0] {
		PH_CLEAR  = 3'd0,
		PH_RED    = 3'd1,
		PH_GREEN  = 3'd2,
		PH_BLUE   = 3'd3,
		PH_SETTLE = 3'd4
	} phase_e;

	localparam logic REG_RECOGNIZE = 1'b0;
	localparam logic REG_SCALING   = 1'b1;

	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 64;

	// One result item as it appears on the result ports.
	typedef struct packed {
		logic [1:0]  filter;
		logic [1:0]  pins;
		logic        balanced;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [2:0]  cls;
		logic        triple;
	} window_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	// One row of the directed plan: either an item or a register write. An item
	// row with typed set carries its expected result; otherwise the predictor
	// supplies it.
	typedef struct packed {
		row_kind_e   kind;
		logic        reg_idx;
		logic [1:0]  reg_val;
		logic [15:0] count;
		logic        typed;
		window_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        full;
	logic [15:0] pulse_count = 16'h0000;
	logic        pop         = 1'b0;
	logic        empty;
	logic [1:0]  filter_select;
	logic [1:0]  scale_pins;
	logic        balanced;
	logic [15:0] red_level;
	logic [15:0] green_level;
	logic [15:0] blue_level;
	logic [2:0]  color_class;
	logic        triple_done;
	logic        cfg_we      = 1'b0;
	logic        cfg_index   = 1'b0;
	logic [1:0]  cfg_data    = 2'd0;

	color_sensor_balance_and_classify DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pulse_count  (pulse_count),
		.pop          (pop),
		.empty        (empty),
		.filter_select(filter_select),
		.scale_pins   (scale_pins),
		.balanced     (balanced),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.color_class  (color_class),
		.triple_done  (triple_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Register mirrors, tracked on every write.
	logic   rec_on     = 1'b0;
	scale_e scale_code = SCALE_20PCT;

	// Predictor state, starting from the values the block takes at reset.
	phase_e      seq_phase  = PH_CLEAR;
	logic        balance_ok = 1'b0;
	logic [15:0] white_ref [0:2] = '{16'h0, 16'h0, 16'h0};
	logic [15:0] level     [0:2] = '{16'h0, 16'h0, 16'h0};
	color_e      class_now  = CLS_NONE;

	// Expected results, oldest first.
	window_t window_q [$];

	int err_count    = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int class_seen [0:5] = '{0, 0, 0, 0, 0, 0};
	int send_burst   = 0;
	int pop_burst    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Packed {lo, hi} bounds of one lane of a color box.
	function automatic logic [15:0] box_of(color_e c, logic [1:0] lane);
		case (c)
			CLS_WHITE: return {8'd235, 8'd255};
			CLS_BLACK: return {8'd10, 8'd50};
			CLS_RED: begin
				case (lane)
					csbc_pkg::LANE_RED:   return {8'd155, 8'd195};
					csbc_pkg::LANE_GREEN: return {8'd26, 8'd66};
					default:              return {8'd37, 8'd77};
				endcase
			end
			CLS_GREEN: begin
				case (lane)
					csbc_pkg::LANE_RED:   return {8'd25, 8'd65};
					csbc_pkg::LANE_GREEN: return {8'd70, 8'd110};
					default:              return {8'd53, 8'd93};
				endcase
			end
			CLS_BLUE: begin
				case (lane)
					csbc_pkg::LANE_RED:   return {8'd26, 8'd66};
					csbc_pkg::LANE_GREEN: return {8'd39, 8'd79};
					default:              return {8'd73, 8'd113};
				endcase
			end
			default: return 16'h0000;
		endcase
	endfunction

	// count*255/ref with saturation; a zero reference pins the lane at full scale.
	function automatic logic [15:0] scale_count(logic [15:0] c, logic [15:0] r);
		logic [31:0] q;
		if (r == 16'h0000)
			return 16'hFFFF;
		q = (32'(c) * 32'd255) / 32'(r);
		return (q > 32'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	// Try the boxes in priority order; the first one holding all three levels wins.
	function automatic color_e classify_levels();
		logic [15:0] b;
		logic        hit;
		for (int c = CLS_WHITE; c <= CLS_BLUE; c++) begin
			hit = 1'b1;
			for (int l = 0; l < 3; l++) begin
				b = box_of(color_e'(c), 2'(l));
				if (level[l] < b[15:8] || level[l] > b[7:0])
					hit = 1'b0;
			end
			if (hit)
				return color_e'(c);
		end
		return CLS_NONE;
	endfunction

	// Advance the predictor by one counting window and return the result it posts.
	function automatic window_t take_window(logic [15:0] count);
		window_t w;
		w.triple = 1'b0;
		if (!balance_ok) begin
			// White balance: capture the three references, then one settle window.
			case (seq_phase)
				PH_CLEAR: seq_phase = PH_RED;
				PH_RED: begin
					white_ref[csbc_pkg::LANE_RED] = count;
					seq_phase = PH_GREEN;
				end
				PH_GREEN: begin
					white_ref[csbc_pkg::LANE_GREEN] = count;
					seq_phase = PH_BLUE;
				end
				PH_BLUE: begin
					white_ref[csbc_pkg::LANE_BLUE] = count;
					seq_phase = PH_SETTLE;
				end
				PH_SETTLE: begin
					balance_ok = 1'b1;
					seq_phase = PH_CLEAR;
				end
				default: seq_phase = PH_CLEAR;
			endcase
		end else if (rec_on) begin
			case (seq_phase)
				PH_CLEAR: seq_phase = PH_RED;
				PH_RED: begin
					level[csbc_pkg::LANE_RED] =
						scale_count(count, white_ref[csbc_pkg::LANE_RED]);
					seq_phase = PH_GREEN;
				end
				PH_GREEN: begin
					level[csbc_pkg::LANE_GREEN] =
						scale_count(count, white_ref[csbc_pkg::LANE_GREEN]);
					seq_phase = PH_BLUE;
				end
				PH_BLUE: begin
					level[csbc_pkg::LANE_BLUE] =
						scale_count(count, white_ref[csbc_pkg::LANE_BLUE]);
					class_now = classify_levels();
					w.triple = 1'b1;
					seq_phase = PH_CLEAR;
				end
				default: seq_phase = PH_CLEAR;
			endcase
		end
		// Balanced with recognition off: hold everything, repeat the outputs.
		w.filter   = (seq_phase inside {PH_RED, PH_GREEN, PH_BLUE}) ?
			seq_phase[1:0] : FILTER_CLEAR;
		w.pins     = scale_code;
		w.balanced = balance_ok;
		w.red      = level[csbc_pkg::LANE_RED];
		w.green    = level[csbc_pkg::LANE_GREEN];
		w.blue     = level[csbc_pkg::LANE_BLUE];
		w.cls      = class_now;
		return w;
	endfunction

	// Expected result with all levels still at zero and no triple.
	function automatic window_t quiet_window(logic [1:0] f, logic [1:0] p, logic b,
			logic [2:0] c);
		window_t w;
		w = '0;
		w.filter   = f;
		w.pins     = p;
		w.balanced = b;
		w.cls      = c;
		return w;
	endfunction

	function automatic stim_row_t item_row(logic [15:0] count);
		stim_row_t r;
		r = '0;
		r.kind  = ROW_ITEM;
		r.count = count;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [15:0] count, window_t want);
		stim_row_t r;
		r = item_row(count);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic idx, logic [1:0] val);
		stim_row_t r;
		r = '0;
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Idle draw shared by both sides: mostly a random idle gap, with bursts of no idling.
	task automatic draw_gap(inout int burst, output int gap);
		if (burst > 0) begin
			burst--;
			gap = 0;
		end else if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(8, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 15);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH at result %0d, %s: got 0x%0h, want 0x%0h",
			results_seen, what, got, want);
		err_count++;
	endtask

	// Offer one item; on acceptance, log its expected result. Push stays high
	// afterward so a back-to-back item needs no second assignment in the step.
	task automatic send_item(logic [15:0] count, logic typed, window_t want);
		int      gap;
		window_t pred;
		draw_gap(send_burst, gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		pulse_count <= count;
		do @(posedge clk); while (full);
		pred = take_window(count);
		window_q.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Write a register once every expected result has come back.
	task automatic write_reg(logic idx, logic [1:0] val);
		push <= 1'b0;
		while (window_q.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RECOGNIZE)
			rec_on = val[0];
		else
			scale_code = scale_e'(val);
		// Let the clock sample the write enable low before anything else drives it.
		@(posedge clk);
	endtask

	// Result side: stall at random, take each item and compare it with the oldest
	// expectation.
	initial begin
		int      gap;
		window_t got;
		window_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			draw_gap(pop_burst, gap);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {filter_select, scale_pins, balanced, red_level, green_level,
				blue_level, color_class, triple_done};
			if (window_q.size() == 0) begin
				report_mismatch("result with no item waiting", got, 0);
			end else begin
				want = window_q.pop_front();
				if (got.filter !== want.filter)
					report_mismatch("filter_select", got.filter, want.filter);
				if (got.pins !== want.pins)
					report_mismatch("scale_pins", got.pins, want.pins);
				if (got.balanced !== want.balanced)
					report_mismatch("balanced", got.balanced, want.balanced);
				if (got.red !== want.red)
					report_mismatch("red_level", got.red, want.red);
				if (got.green !== want.green)
					report_mismatch("green_level", got.green, want.green);
				if (got.blue !== want.blue)
					report_mismatch("blue_level", got.blue, want.blue);
				if (got.cls !== want.cls)
					report_mismatch("color_class", got.cls, want.cls);
				if (got.triple !== want.triple)
					report_mismatch("triple_done", got.triple, want.triple);
			end
			if (got.triple === 1'b1 && got.cls <= CLS_BLUE)
				class_seen[got.cls]++;
			results_seen++;
		end
	end

	// Stimulus: reset, directed plan, then random phases.
	initial begin
		stim_row_t   plan [$];
		stim_row_t   row;
		int          active;
		int          n;
		int          mode;
		int          lvl;
		logic [1:0]  lane;
		logic [15:0] b;
		logic [15:0] count;
		color_e      aim;

		// Balance runs only once after reset, so these references hold for the
		// whole run. They stay nonzero so every color box can be reached; red at
		// 254 lets the top counts saturate and green at 255 scales one to one.
		plan.push_back(typed_row(16'hFFFF,
			quiet_window(FILTER_RED, SCALE_20PCT, 1'b0, CLS_NONE)));
		plan.push_back(typed_row(16'd254,
			quiet_window(FILTER_GREEN, SCALE_20PCT, 1'b0, CLS_NONE)));
		plan.push_back(typed_row(16'd255,
			quiet_window(FILTER_BLUE, SCALE_20PCT, 1'b0, CLS_NONE)));
		plan.push_back(typed_row(16'd200,
			quiet_window(FILTER_CLEAR, SCALE_20PCT, 1'b0, CLS_NONE)));
		plan.push_back(typed_row(16'h0000,
			quiet_window(FILTER_CLEAR, SCALE_20PCT, 1'b1, CLS_NONE)));
		// Balanced with recognition still off: outputs repeat.
		plan.push_back(typed_row(16'hFFFF,
			quiet_window(FILTER_CLEAR, SCALE_20PCT, 1'b1, CLS_NONE)));
		plan.push_back(reg_row(REG_RECOGNIZE, 2'd1));
		plan.push_back(reg_row(REG_SCALING, SCALE_FULL));
		plan.push_back(typed_row(16'h0000,
			quiet_window(FILTER_RED, SCALE_FULL, 1'b1, CLS_NONE)));
		// Saturated red and blue, zero green: no box matches.
		plan.push_back(item_row(16'hFFFF));
		plan.push_back(item_row(16'h0000));
		plan.push_back(item_row(16'hFFFF));
		// White, then black.
		plan.push_back(item_row(16'h0000));
		plan.push_back(item_row(16'd240));
		plan.push_back(item_row(16'd240));
		plan.push_back(item_row(16'd190));
		plan.push_back(item_row(16'h0000));
		plan.push_back(item_row(16'd30));
		plan.push_back(item_row(16'd30));
		plan.push_back(item_row(16'd24));
		// Red, with recognition switched off in the middle of the triple.
		plan.push_back(reg_row(REG_SCALING, SCALE_OFF));
		plan.push_back(item_row(16'h0000));
		plan.push_back(item_row(16'd175));
		plan.push_back(reg_row(REG_RECOGNIZE, 2'd0));
		plan.push_back(item_row(16'hFFFF));
		plan.push_back(reg_row(REG_RECOGNIZE, 2'd1));
		plan.push_back(item_row(16'd46));
		plan.push_back(item_row(16'd45));
		plan.push_back(reg_row(REG_SCALING, SCALE_2PCT));

		// Hold reset, then release it for good.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_REG)
				write_reg(row.reg_idx, row.reg_val);
			else
				send_item(row.count, row.typed, row.want);
		end

		// Random phases: new register settings once the block drains, then a run of
		// items. Most counts are aimed at one color box per triple so that every
		// class comes up; the rest are noise, small counts, and near-full or zero counts.
		active = 0;
		aim = CLS_NONE;
		while (active < RANDOM_ITEMS) begin
			write_reg(REG_RECOGNIZE, 2'($urandom_range(0, 7) != 0));
			write_reg(REG_SCALING, 2'($urandom_range(SCALE_OFF, SCALE_FULL)));
			n = rec_on ? $urandom_range(30, 70) : $urandom_range(4, 12);
			repeat (n) begin
				if (seq_phase == PH_CLEAR)
					aim = color_e'($urandom_range(CLS_NONE, CLS_BLUE));
				mode = $urandom_range(0, 9);
				if (seq_phase inside {PH_RED, PH_GREEN, PH_BLUE} && aim != CLS_NONE &&
						mode < 6) begin
					// Invert the scaling so the level lands inside the box.
					lane  = 2'(seq_phase - PH_RED);
					b     = box_of(aim, lane);
					lvl   = $urandom_range(b[15:8], b[7:0]);
					count = 16'((lvl * white_ref[lane]) / 255 + $urandom_range(0, 1));
				end else if (mode < 8) begin
					count = 16'($urandom);
				end else if (mode == 8) begin
					count = 16'($urandom_range(0, 300));
				end else begin
					count = ($urandom_range(0, 1) != 0) ?
						16'($urandom_range(65100, 65535)) : 16'h0000;
				end
				send_item(count, 1'b0, '0);
				if (rec_on)
					active++;
			end
		end

		// Drain: wait for every expected result, then give the back end time to
		// show any stray item.
		push <= 1'b0;
		while (window_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d items sent, %0d results checked, %0d mismatches",
			items_sent, results_seen, err_count);
		$display("Summary: triples classified none/white/black/red/green/blue = %0d/%0d/%0d/%0d/%0d/%0d",
			class_seen[0], class_seen[1], class_seen[2], class_seen[3],
			class_seen[4], class_seen[5]);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/csbc_pkg.sv
rtl/core/csbc_cmd_fifo.sv
rtl/core/csbc_front.sv
rtl/core/csbc_back.sv
rtl/core/color_sensor_balance_and_classify.sv
sim/color_sensor_balance_and_classify_tb.sv
